// ===== rtl/core/planar_yuv_to_uyvy_packer_top_defines.svh =====
// ----------------------------------------------------------------------------
// planar yuv to uyvy packer - assertion macros
// shared helpers for the concurrent checks on the packer ports
// ----------------------------------------------------------------------------
`ifndef PLANAR_YUV_TO_UYVY_PACKER_TOP_DEFINES_SVH
`define PLANAR_YUV_TO_UYVY_PACKER_TOP_DEFINES_SVH

// generic clocked check, disabled while the active-low reset is asserted
`define PYUP_CHECK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pyup check failed");

// check on the packer clock and reset
`define PYUP_CHECK_CLK(lbl, prop) `PYUP_CHECK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== rtl/core/pyup_pkg.sv =====
// ----------------------------------------------------------------------------
// pyup_pkg
// types and constants shared by the planar yuv to uyvy packer
// ----------------------------------------------------------------------------
package pyup_pkg;

    localparam logic [7:0] BLACK_CHROMA = 8'h80;
    localparam logic [7:0] BLACK_LUMA   = 8'h10;

    localparam logic [12:0] RST_LINE_WIDTH   = 13'd720;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd576;

    localparam int unsigned CfgAddrW = 4;
    localparam int unsigned CfgDataW = 32;

    typedef enum logic [1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_CHROMA_MODE  = 2'd2,
        REG_SHIFT_UP     = 2'd3
    } t_reg_idx;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FILL  = 1'b1
    } t_req_type;

    typedef enum logic {
        MODE_420 = 1'b0,
        MODE_411 = 1'b1
    } t_chroma_mode;

    // frame geometry as seen by the datapath
    typedef struct packed {
        logic [12:0]  last_pair;
        logic [12:0]  last_row;
        t_chroma_mode chroma_mode;
        logic         shift_up;
    } t_limits;

    // per-request decisions taken at acceptance
    typedef struct packed {
        logic fill;
        logic drop;
        logic blend;
        logic line_end;
    } t_s1_ctrl;

endpackage

// ===== rtl/core/planar_yuv_to_uyvy_packer_top.sv =====
// ----------------------------------------------------------------------------
// planar_yuv_to_uyvy_packer_top
// a result passes through the input stage and then the result register; one
// pixel pair per cycle unless the output stalls, set by these two registers
// a stalled result register still lets one more request into the input stage
// reset clears both pipeline stages and the pair and row counters, and loads
// the registers with 720 pixels, 576 lines, 4:2:0 mode and no shift-up
// ----------------------------------------------------------------------------
module planar_yuv_to_uyvy_packer_top #(
    parameter int unsigned MAX_LINE_WIDTH   = 4096,
    parameter int unsigned MAX_FRAME_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pyup_pkg::CfgAddrW-1:0]  paddr,
    input  logic [pyup_pkg::CfgDataW-1:0]  pwdata,
    output logic [pyup_pkg::CfgDataW-1:0]  prdata,
    output logic                           pready,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_req_type,
    input  logic [7:0]                     i_luma_first,
    input  logic [7:0]                     i_luma_second,
    input  logic [7:0]                     i_cb_here,
    input  logic [7:0]                     i_cr_here,
    input  logic [7:0]                     i_cb_other,
    input  logic [7:0]                     i_cr_other,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_u,
    output logic [7:0]                     o_out_y_even,
    output logic [7:0]                     o_out_v,
    output logic [7:0]                     o_out_y_odd,
    output logic                           o_line_last
);
    import pyup_pkg::*;

    localparam int unsigned ColW = $clog2(MAX_LINE_WIDTH / 2);
    localparam int unsigned RowW = $clog2(MAX_FRAME_HEIGHT);

    t_limits          limits;

    logic [ColW-1:0]  r_col;
    logic [ColW-1:0]  n_col;
    logic [RowW-1:0]  r_row;
    logic [RowW-1:0]  n_row;

    logic             r_s1_valid;
    t_s1_ctrl         r_s1_ctrl;
    t_s1_ctrl         n_s1_ctrl;
    logic [7:0]       r_s1_y0;
    logic [7:0]       r_s1_y1;
    logic [7:0]       r_s1_cb;
    logic [7:0]       r_s1_cr;
    logic [7:0]       r_s1_cbo;
    logic [7:0]       r_s1_cro;

    logic             r_out_valid;
    logic [7:0]       r_out_u;
    logic [7:0]       r_out_y_even;
    logic [7:0]       r_out_v;
    logic [7:0]       r_out_y_odd;
    logic             r_line_last;
    logic [7:0]       n_out_u;
    logic [7:0]       n_out_v;

    logic             in_accept;
    logic             out_free;
    logic             s1_leave;
    logic             at_line_end;
    logic             at_last_row;
    logic             is_fill;
    logic [8:0]       sum_u;
    logic [8:0]       sum_v;

    pyup_regs #(
        .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
        .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (limits)
    );

    // handshake: a dropped request leaves stage 1 without needing the result slot
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_leave   = r_s1_valid && (out_free || r_s1_ctrl.drop);
    assign o_in_stall = r_s1_valid && !s1_leave;
    assign in_accept  = i_in_valid && !o_in_stall;

    // position decisions from the counters
    always_comb begin
        at_line_end = 13'(r_col) >= limits.last_pair;
        at_last_row = 13'(r_row) >= limits.last_row;
        is_fill     = (t_req_type'(i_req_type) == REQ_FILL);

        n_s1_ctrl.fill     = is_fill;
        n_s1_ctrl.line_end = at_line_end;
        n_s1_ctrl.drop     = !is_fill && limits.shift_up && (r_row == '0);
        unique case (limits.chroma_mode)
            MODE_420: n_s1_ctrl.blend = r_row[0] && !at_last_row;
            MODE_411: n_s1_ctrl.blend = r_col[0] && !at_line_end;
        endcase

        n_col = at_line_end ? '0 : r_col + ColW'(1);
        n_row = r_row;
        // fill lines leave the row count alone
        if (!is_fill && at_line_end) begin
            n_row = at_last_row ? '0 : r_row + RowW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_leave) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctrl <= n_s1_ctrl;
            r_s1_y0   <= i_luma_first;
            r_s1_y1   <= i_luma_second;
            r_s1_cb   <= i_cb_here;
            r_s1_cr   <= i_cr_here;
            r_s1_cbo  <= i_cb_other;
            r_s1_cro  <= i_cr_other;
        end
    end

    // black on fill, floor average of both chroma samples on blend, else own samples
    always_comb begin
        sum_u = {1'b0, r_s1_cb} + {1'b0, r_s1_cbo};
        sum_v = {1'b0, r_s1_cr} + {1'b0, r_s1_cro};
        priority if (r_s1_ctrl.fill) begin
            n_out_u = BLACK_CHROMA;
            n_out_v = BLACK_CHROMA;
        end else if (r_s1_ctrl.blend) begin
            n_out_u = sum_u[8:1];
            n_out_v = sum_v[8:1];
        end else begin
            n_out_u = r_s1_cb;
            n_out_v = r_s1_cr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid && !r_s1_ctrl.drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid && !r_s1_ctrl.drop) begin
            r_out_u      <= n_out_u;
            r_out_v      <= n_out_v;
            r_out_y_even <= r_s1_ctrl.fill ? BLACK_LUMA : r_s1_y0;
            r_out_y_odd  <= r_s1_ctrl.fill ? BLACK_LUMA : r_s1_y1;
            r_line_last  <= r_s1_ctrl.line_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_u      = r_out_u;
    assign o_out_y_even = r_out_y_even;
    assign o_out_v      = r_out_v;
    assign o_out_y_odd  = r_out_y_odd;
    assign o_line_last  = r_line_last;

endmodule

// ===== rtl/core/pyup_regs.sv =====
// ----------------------------------------------------------------------------
// pyup_regs
// apb register file for the packer with clamped line and frame limits
// ----------------------------------------------------------------------------
module pyup_regs #(
    parameter int unsigned MAX_LINE_WIDTH   = 4096,
    parameter int unsigned MAX_FRAME_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pyup_pkg::CfgAddrW-1:0]  paddr,
    input  logic [pyup_pkg::CfgDataW-1:0]  pwdata,
    output logic [pyup_pkg::CfgDataW-1:0]  prdata,
    output logic                           pready,
    output pyup_pkg::t_limits              o_limits
);
    import pyup_pkg::*;

    localparam logic [13:0] LwMax = 14'(MAX_LINE_WIDTH);
    localparam logic [13:0] FhMax = 14'(MAX_FRAME_HEIGHT);

    logic [12:0]  r_line_width;
    logic [12:0]  r_frame_height;
    t_chroma_mode r_chroma_mode;
    logic         r_shift_up;

    logic         wr_en;
    t_reg_idx     reg_idx;
    logic [13:0]  lw_ext;
    logic [13:0]  lw_clamp;
    logic [13:0]  fh_ext;
    logic [13:0]  fh_clamp;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_chroma_mode  <= MODE_420;
            r_shift_up     <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LINE_WIDTH:   r_line_width   <= pwdata[12:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[12:0];
                REG_CHROMA_MODE:  r_chroma_mode  <= t_chroma_mode'(pwdata[0]);
                REG_SHIFT_UP:     r_shift_up     <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINE_WIDTH:   prdata = CfgDataW'(r_line_width);
            REG_FRAME_HEIGHT: prdata = CfgDataW'(r_frame_height);
            REG_CHROMA_MODE:  prdata = CfgDataW'(r_chroma_mode);
            REG_SHIFT_UP:     prdata = CfgDataW'(r_shift_up);
        endcase
    end

    // clamp to the supported range, width rounded down to a multiple of four
    always_comb begin
        lw_ext = {1'b0, r_line_width};
        fh_ext = {1'b0, r_frame_height};
        priority if (lw_ext < 14'd4) begin
            lw_clamp = 14'd4;
        end else if (lw_ext > LwMax) begin
            lw_clamp = LwMax;
        end else begin
            lw_clamp = lw_ext;
        end
        priority if (fh_ext < 14'd2) begin
            fh_clamp = 14'd2;
        end else if (fh_ext > FhMax) begin
            fh_clamp = FhMax;
        end else begin
            fh_clamp = fh_ext;
        end
    end

    always_comb begin
        o_limits.last_pair   = {1'b0, lw_clamp[13:2]} + {1'b0, lw_clamp[13:2]} - 13'd1;
        o_limits.last_row    = 13'(fh_clamp - 14'd1);
        o_limits.chroma_mode = r_chroma_mode;
        o_limits.shift_up    = r_shift_up;
    end

endmodule

// ===== rtl/core/pyup_chk.sv =====
// ----------------------------------------------------------------------------
// pyup_chk
// port-level checks on the packer, attached to the top level by bind
// ----------------------------------------------------------------------------
`include "planar_yuv_to_uyvy_packer_top_defines.svh"

module pyup_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_u,
    input logic [7:0] o_out_y_even,
    input logic [7:0] o_out_v,
    input logic [7:0] o_out_y_odd,
    input logic       o_line_last
);

    logic [32:0] out_word;

    assign out_word = {o_out_u, o_out_y_even, o_out_v, o_out_y_odd, o_line_last};

    // a stalled result stays offered
    `PYUP_CHECK_CLK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid)

    // and its word does not move
    `PYUP_CHECK_CLK(a_out_stable, o_out_valid && i_out_stall |=> $stable(out_word))

    // the request side only backs up behind a full, stalled result register
    `PYUP_CHECK_CLK(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall)

    // a fresh result comes from a request taken into the input stage, then the result register
    `PYUP_CHECK_CLK(a_out_origin, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))

endmodule

bind planar_yuv_to_uyvy_packer_top pyup_chk u_pyup_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out_u      (o_out_u),
    .o_out_y_even (o_out_y_even),
    .o_out_v      (o_out_v),
    .o_out_y_odd  (o_out_y_odd),
    .o_line_last  (o_line_last)
);
